[rtl/qau_pkg.sv]
// ----------------------------------------------------------------------------
// qau_pkg
// Shared widths, operation codes, stage record and clamp helper for the
// quaternion arithmetic unit.
// ----------------------------------------------------------------------------
package qau_pkg;

  localparam int WORD_BITS = 16;
  localparam int FRAC_BITS = 12;

  localparam int PROD_W = 2 * WORD_BITS;          // one component product
  localparam int SUM_W  = PROD_W + 2;             // sum of four products, signed
  localparam int DEN_W  = PROD_W + 1;             // norm, unsigned
  localparam int QB     = WORD_BITS + 1;          // quotient / root bits
  localparam int NUM_W  = DEN_W + FRAC_BITS;      // dividend
  localparam int RAD_W  = 2 * QB;                 // radicand
  localparam int SREM_W = QB + 2;                 // root remainder
  localparam int HALF   = 2 ** (WORD_BITS - 1);

  localparam logic [2:0] FN_ADD  = 3'd0;
  localparam logic [2:0] FN_SUB  = 3'd1;
  localparam logic [2:0] FN_MUL  = 3'd2;
  localparam logic [2:0] FN_INV  = 3'd3;
  localparam logic [2:0] FN_DIV  = 3'd4;
  localparam logic [2:0] FN_CONJ = 3'd5;
  localparam logic [2:0] FN_MAG  = 3'd6;

  // Hamilton product: part c sums a[t] * b[c ^ t]; this table marks the
  // terms that are subtracted.
  localparam logic [3:0][3:0] TERM_NEG = '{
    4'b0100,   // part 3: k
    4'b0010,   // part 2: j
    4'b1000,   // part 1: i
    4'b1110    // part 0: real
  };

  // record carried by the divide / root stages
  typedef struct packed {
    logic                            use_div;
    logic                            use_sqrt;
    logic                            zero_norm;
    logic                            sat;
    logic [3:0][WORD_BITS-1:0]       res;
    logic [3:0]                      neg;
    logic [3:0]                      ovf;
    logic [3:0][QB-1:0]              nrest;
    logic [3:0][DEN_W-1:0]           rem;
    logic [3:0][QB-1:0]              quo;
    logic [DEN_W-1:0]                den;
    logic [RAD_W-1:0]                rad;
    logic [SREM_W-1:0]               srem;
    logic [QB-1:0]                   root;
  } iter_t;

  // clamp a magnitude to the word range and apply the sign; MSB is the
  // saturation flag
  function automatic logic [WORD_BITS:0] clamp_mag(input logic neg,
                                                   input logic [SUM_W:0] mag);
    logic [SUM_W:0]         lim;
    logic [WORD_BITS-1:0]   v;
    logic                   s;
    lim = neg ? (SUM_W+1)'(HALF) : (SUM_W+1)'(HALF - 1);
    s   = mag > lim;
    v   = s ? lim[WORD_BITS-1:0] : mag[WORD_BITS-1:0];
    if (neg) begin
      v = -v;
    end
    return {s, v};
  endfunction

endpackage

[rtl/qau_iter_stage.sv]
// ----------------------------------------------------------------------------
// qau_iter_stage
// One registered step: one quotient bit for each of the four divide lanes
// and one root bit for the square root.
// ----------------------------------------------------------------------------
module qau_iter_stage import qau_pkg::*; (
  input  logic  clk_i,
  input  logic  rst_ni,
  input  logic  vld_i,
  input  iter_t data_i,
  output logic  vld_o,
  output iter_t data_o
);

  iter_t data_d, data_q;
  logic  vld_q;

  logic [DEN_W:0]    t_div [4];
  logic              qbit  [4];
  logic [SREM_W+1:0] t_rt;
  logic [SREM_W+1:0] trial;
  logic              rbit;

  always_comb begin
    data_d = data_i;
    for (int c = 0; c < 4; c++) begin
      t_div[c] = {data_i.rem[c], data_i.nrest[c][QB-1]};
      qbit[c]  = t_div[c] >= {1'b0, data_i.den};
      if (qbit[c]) begin
        data_d.rem[c] = DEN_W'(t_div[c] - {1'b0, data_i.den});
      end else begin
        data_d.rem[c] = t_div[c][DEN_W-1:0];
      end
      data_d.quo[c]   = {data_i.quo[c][QB-2:0], qbit[c]};
      data_d.nrest[c] = {data_i.nrest[c][QB-2:0], 1'b0};
    end
    // digit-by-digit root, two radicand bits a step
    t_rt  = {data_i.srem, data_i.rad[RAD_W-1 -: 2]};
    trial = {{(SREM_W-QB){1'b0}}, data_i.root, 2'b01};
    rbit  = t_rt >= trial;
    if (rbit) begin
      data_d.srem = SREM_W'(t_rt - trial);
    end else begin
      data_d.srem = t_rt[SREM_W-1:0];
    end
    data_d.root = {data_i.root[QB-2:0], rbit};
    data_d.rad  = {data_i.rad[RAD_W-3:0], 2'b00};
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= 1'b0;
    end else begin
      vld_q <= vld_i;
    end
  end

  always_ff @(posedge clk_i) begin
    data_q <= data_d;
  end

  assign vld_o  = vld_q;
  assign data_o = data_q;

endmodule

[rtl/quaternion_arithmetic_unit.sv]
// ----------------------------------------------------------------------------
// quaternion_arithmetic_unit
// Pipelined quaternion ALU on signed Q4.12 components.
// ----------------------------------------------------------------------------
// Usage:
//   An item (func_i plus operands a and b) is taken at each clock edge with
//   start high; busy is always low, so one item can enter every cycle.
//   Operations: add, sub, Hamilton product, inverse of a, a / b, conjugate
//   of a and magnitude of a (in r_re_o, other parts zero).
//   Each result shows on the r_*_o ports for exactly one cycle with done_o
//   high, in the order of entry.
//   The restoring divider and square root make one quotient / root bit per
//   stage over 17 stages, after a multiply stage, a summing stage and a
//   set-up stage, and feed a final rounding and output register.
//   Throughput: one item per cycle for every operation.
//   saturated_o flags a clamped part; zero_norm_o flags inverse or divide
//   with a zero norm, which gives an all-zero result.
//   Reset clears only the valid bits; items in flight are dropped.
//   The receiver cannot hold results off; none is needed since the
//   pipeline never stalls.
// ----------------------------------------------------------------------------
module quaternion_arithmetic_unit import qau_pkg::*; (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        start,
  output logic                        busy,
  input  logic [2:0]                  func_i,
  input  logic signed [WORD_BITS-1:0] a_re_i,
  input  logic signed [WORD_BITS-1:0] a_i_i,
  input  logic signed [WORD_BITS-1:0] a_j_i,
  input  logic signed [WORD_BITS-1:0] a_k_i,
  input  logic signed [WORD_BITS-1:0] b_re_i,
  input  logic signed [WORD_BITS-1:0] b_i_i,
  input  logic signed [WORD_BITS-1:0] b_j_i,
  input  logic signed [WORD_BITS-1:0] b_k_i,
  output logic                        done_o,
  output logic signed [WORD_BITS-1:0] r_re_o,
  output logic signed [WORD_BITS-1:0] r_i_o,
  output logic signed [WORD_BITS-1:0] r_j_o,
  output logic signed [WORD_BITS-1:0] r_k_o,
  output logic                        zero_norm_o,
  output logic                        saturated_o
);

  assign busy = 1'b0;

  // ---------------- stage 1: products ----------------
  logic signed [WORD_BITS-1:0] a_w [4];
  logic signed [WORD_BITS-1:0] b_w [4];
  logic signed [WORD_BITS-1:0] x_w [4];

  assign a_w[0] = a_re_i;
  assign a_w[1] = a_i_i;
  assign a_w[2] = a_j_i;
  assign a_w[3] = a_k_i;
  assign b_w[0] = b_re_i;
  assign b_w[1] = b_i_i;
  assign b_w[2] = b_j_i;
  assign b_w[3] = b_k_i;

  logic                        s1_vld_q;
  logic [2:0]                  s1_func_q;
  logic signed [WORD_BITS-1:0] s1_a_q    [4];
  logic signed [WORD_BITS-1:0] s1_b_q    [4];
  logic signed [PROD_W-1:0]    s1_prod_q [4][4];
  logic signed [PROD_W-1:0]    s1_sq_q   [4];

  always_comb begin
    for (int t = 0; t < 4; t++) begin
      x_w[t] = (func_i == FN_DIV) ? b_w[t] : a_w[t];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_vld_q <= 1'b0;
    end else begin
      s1_vld_q <= start;
    end
  end

  always_ff @(posedge clk_i) begin
    s1_func_q <= func_i;
    for (int c = 0; c < 4; c++) begin
      s1_a_q[c]  <= a_w[c];
      s1_b_q[c]  <= b_w[c];
      s1_sq_q[c] <= x_w[c] * x_w[c];
      for (int t = 0; t < 4; t++) begin
        s1_prod_q[c][t] <= a_w[t] * b_w[2'(c ^ t)];
      end
    end
  end

  // ---------------- stage 2: sums ----------------
  logic signed [SUM_W-1:0]     ham_d  [4];
  logic [DEN_W-1:0]            norm_d;
  logic signed [WORD_BITS:0]   simp_v [4];
  logic [WORD_BITS:0]          simp_a [4];
  logic [WORD_BITS:0]          simp_c [4];
  logic                        tneg;

  logic                        s2_vld_q;
  logic [2:0]                  s2_func_q;
  logic signed [WORD_BITS-1:0] s2_a_q    [4];
  logic signed [SUM_W-1:0]     s2_ham_q  [4];
  logic [DEN_W-1:0]            s2_norm_q;
  logic [WORD_BITS:0]          s2_simp_q [4];   // {sat, word}

  always_comb begin
    norm_d = '0;
    for (int c = 0; c < 4; c++) begin
      ham_d[c] = '0;
      for (int t = 0; t < 4; t++) begin
        // dividing uses conj(b): every term on an imaginary part of b flips
        tneg = TERM_NEG[c][t] ^ ((s1_func_q == FN_DIV) && ((c ^ t) != 0));
        ham_d[c] = ham_d[c] + (tneg ? -SUM_W'(s1_prod_q[c][t])
                                    :  SUM_W'(s1_prod_q[c][t]));
      end
      norm_d = norm_d + DEN_W'($unsigned(s1_sq_q[c]));

      unique case (s1_func_q)
        FN_ADD:  simp_v[c] = (WORD_BITS+1)'(s1_a_q[c]) + (WORD_BITS+1)'(s1_b_q[c]);
        FN_SUB:  simp_v[c] = (WORD_BITS+1)'(s1_a_q[c]) - (WORD_BITS+1)'(s1_b_q[c]);
        FN_CONJ: simp_v[c] = (c == 0) ?  (WORD_BITS+1)'(s1_a_q[c])
                                      : -(WORD_BITS+1)'(s1_a_q[c]);
        default: simp_v[c] = '0;
      endcase
      simp_a[c] = simp_v[c][WORD_BITS] ? (WORD_BITS+1)'(-simp_v[c])
                                       : (WORD_BITS+1)'(simp_v[c]);
      simp_c[c] = clamp_mag(simp_v[c][WORD_BITS], (SUM_W+1)'(simp_a[c]));
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s2_vld_q <= 1'b0;
    end else begin
      s2_vld_q <= s1_vld_q;
    end
  end

  always_ff @(posedge clk_i) begin
    s2_func_q <= s1_func_q;
    s2_norm_q <= norm_d;
    for (int c = 0; c < 4; c++) begin
      s2_a_q[c]    <= s1_a_q[c];
      s2_ham_q[c]  <= ham_d[c];
      s2_simp_q[c] <= simp_c[c];
    end
  end

  // ---------------- stage 3: rounding and divide set-up ----------------
  iter_t                 init_d;
  logic                  hneg  [4];
  logic [SUM_W-1:0]      hmag  [4];
  logic [SUM_W:0]        rmag  [4];
  logic [WORD_BITS:0]    mclip [4];
  logic                  aneg  [4];
  logic [WORD_BITS-1:0]  aabs  [4];
  logic [NUM_W-1:0]      num   [4];
  logic [NUM_W-QB-1:0]   rem0  [4];
  logic                  is_inv, is_div;

  always_comb begin
    is_inv = s2_func_q == FN_INV;
    is_div = s2_func_q == FN_DIV;
    init_d           = '0;
    init_d.use_div   = is_inv || is_div;
    init_d.use_sqrt  = s2_func_q == FN_MAG;
    init_d.zero_norm = (is_inv || is_div) && (s2_norm_q == '0);
    init_d.den       = s2_norm_q;
    init_d.rad       = RAD_W'(s2_norm_q);
    for (int c = 0; c < 4; c++) begin
      hneg[c]  = s2_ham_q[c][SUM_W-1];
      hmag[c]  = hneg[c] ? SUM_W'(-s2_ham_q[c]) : SUM_W'(s2_ham_q[c]);
      rmag[c]  = (SUM_W+1)'(hmag[c]) + (SUM_W+1)'(2 ** (FRAC_BITS - 1));
      mclip[c] = clamp_mag(hneg[c], rmag[c] >> FRAC_BITS);

      aneg[c] = s2_a_q[c][WORD_BITS-1];
      aabs[c] = aneg[c] ? WORD_BITS'(-s2_a_q[c]) : WORD_BITS'(s2_a_q[c]);
      if (is_inv) begin
        num[c]        = NUM_W'(aabs[c]) << (2 * FRAC_BITS);
        init_d.neg[c] = (c == 0) ? aneg[c] : !aneg[c];
      end else begin
        num[c]        = NUM_W'(hmag[c]) << FRAC_BITS;
        init_d.neg[c] = hneg[c];
      end
      rem0[c]         = num[c][NUM_W-1:QB];
      // quotient of 2^QB or more always clamps
      init_d.ovf[c]   = DEN_W'(rem0[c]) >= s2_norm_q;
      init_d.rem[c]   = DEN_W'(rem0[c]);
      init_d.nrest[c] = num[c][QB-1:0];
    end
    priority if (s2_func_q == FN_MUL) begin
      for (int c = 0; c < 4; c++) begin
        init_d.res[c] = mclip[c][WORD_BITS-1:0];
      end
      init_d.sat = mclip[0][WORD_BITS] | mclip[1][WORD_BITS] |
                   mclip[2][WORD_BITS] | mclip[3][WORD_BITS];
    end else if (s2_func_q == FN_ADD || s2_func_q == FN_SUB ||
                 s2_func_q == FN_CONJ) begin
      for (int c = 0; c < 4; c++) begin
        init_d.res[c] = s2_simp_q[c][WORD_BITS-1:0];
      end
      init_d.sat = s2_simp_q[0][WORD_BITS] | s2_simp_q[1][WORD_BITS] |
                   s2_simp_q[2][WORD_BITS] | s2_simp_q[3][WORD_BITS];
    end else begin
      init_d.sat = 1'b0;
    end
  end

  logic  s3_vld_q;
  iter_t s3_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s3_vld_q <= 1'b0;
    end else begin
      s3_vld_q <= s2_vld_q;
    end
  end

  always_ff @(posedge clk_i) begin
    s3_q <= init_d;
  end

  // ---------------- divide / root stages ----------------
  logic  it_vld  [QB+1];
  iter_t it_data [QB+1];

  assign it_vld[0]  = s3_vld_q;
  assign it_data[0] = s3_q;

  for (genvar g = 0; g < QB; g++) begin : g_iter
    qau_iter_stage u_stage (
      .clk_i  (clk_i),
      .rst_ni (rst_ni),
      .vld_i  (it_vld[g]),
      .data_i (it_data[g]),
      .vld_o  (it_vld[g+1]),
      .data_o (it_data[g+1])
    );
  end

  // ---------------- final rounding and output register ----------------
  iter_t                     fin;
  logic [QB:0]               qr    [4];
  logic [WORD_BITS:0]        dclip [4];
  logic [QB:0]               rr;
  logic [WORD_BITS:0]        sclip;
  logic [3:0][WORD_BITS-1:0] res_d;
  logic                      sat_d, zn_d;

  assign fin = it_data[QB];

  always_comb begin
    for (int c = 0; c < 4; c++) begin
      qr[c] = (QB+1)'(fin.quo[c]) +
              (QB+1)'({fin.rem[c], 1'b0} >= {1'b0, fin.den});
      dclip[c] = clamp_mag(fin.neg[c],
                           fin.ovf[c] ? (SUM_W+1)'(2 * HALF) : (SUM_W+1)'(qr[c]));
    end
    rr    = (QB+1)'(fin.root) + (QB+1)'(fin.srem > SREM_W'(fin.root));
    sclip = clamp_mag(1'b0, (SUM_W+1)'(rr));
    zn_d  = fin.zero_norm;
    priority if (fin.use_div && fin.zero_norm) begin
      res_d = '0;
      sat_d = 1'b0;
    end else if (fin.use_div) begin
      for (int c = 0; c < 4; c++) begin
        res_d[c] = dclip[c][WORD_BITS-1:0];
      end
      sat_d = dclip[0][WORD_BITS] | dclip[1][WORD_BITS] |
              dclip[2][WORD_BITS] | dclip[3][WORD_BITS];
    end else if (fin.use_sqrt) begin
      res_d    = '0;
      res_d[0] = sclip[WORD_BITS-1:0];
      sat_d    = sclip[WORD_BITS];
    end else begin
      res_d = fin.res;
      sat_d = fin.sat;
    end
  end

  logic                      done_q;
  logic [3:0][WORD_BITS-1:0] res_q;
  logic                      sat_q, zn_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      done_q <= 1'b0;
    end else begin
      done_q <= it_vld[QB];
    end
  end

  always_ff @(posedge clk_i) begin
    res_q <= res_d;
    sat_q <= sat_d;
    zn_q  <= zn_d;
  end

  assign done_o      = done_q;
  assign r_re_o      = res_q[0];
  assign r_i_o       = res_q[1];
  assign r_j_o       = res_q[2];
  assign r_k_o       = res_q[3];
  assign zero_norm_o = zn_q;
  assign saturated_o = sat_q;

endmodule
